// File: src/eic_pkg.sv
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types, constants and helper functions for the EAPOL ingress
// classifier: frame summary record, verdict codes, header arithmetic.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int unsigned MAX_CAPTURE_BYTES = 4096;
  localparam int unsigned POS_W             = 12;
  localparam int unsigned POS_LIMIT_INT     =
    ((MAX_CAPTURE_BYTES - 1) < 4095) ? (MAX_CAPTURE_BYTES - 1) : 4095;
  localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(POS_LIMIT_INT);

  localparam logic [POS_W-1:0] DATA_HDR_BYTES = 12'd24;
  localparam logic [POS_W-1:0] FCS_BYTES      = 12'd4;
  localparam int unsigned      PREFIX_BYTES   = 8;
  localparam int unsigned      AP_OCTETS      = 6;
  localparam logic [POS_W-1:0] AP_OFS_TO_DS   = 12'd4;
  localparam logic [POS_W-1:0] AP_OFS_FROM_DS = 12'd10;

  localparam logic [1:0] FC_TYPE_DATA     = 2'd2;
  localparam logic [3:0] SUBTYPE_NULL     = 4'd4;
  localparam logic [3:0] SUBTYPE_QOS_NULL = 4'd12;
  localparam logic [7:0] CHAN_MIN         = 8'd1;
  localparam logic [7:0] CHAN_MAX         = 8'd14;

  // Verdict codes
  localparam logic [1:0] DISP_INVALID = 2'd0;
  localparam logic [1:0] DISP_IGNORE  = 2'd1;
  localparam logic [1:0] DISP_RETAIN  = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  // One finished frame, handed from front to back
  typedef struct packed {
    logic [15:0] fc;
    logic        ap_mismatch;
    logic        snap_mismatch;
    logic [11:0] captured_length;
    logic [15:0] original_length;
    logic        fcs_included;
    logic        is_data_frame;
    logic        timestamp_zero;
    logic [7:0]  channel;
  } frame_sum_t;

  // MAC header length: 24, +2 with QoS, +4 more with QoS and Order
  function automatic logic [POS_W-1:0] hdr_len(input logic [15:0] fc);
    logic [POS_W-1:0] h;
    h = DATA_HDR_BYTES;
    if (fc[7]) h = h + 12'd2;
    if (fc[7] && fc[15]) h = h + 12'd4;
    return h;
  endfunction

  function automatic logic [POS_W-1:0] payload_len(input logic [11:0] cap,
                                                   input logic        fcs);
    logic [POS_W-1:0] l;
    l = cap;
    if (fcs) l = (cap >= FCS_BYTES) ? (cap - FCS_BYTES) : '0;
    return l;
  endfunction

  // LLC/SNAP header expected for EAPOL: aa aa 03 00 00 00 88 8e
  function automatic logic [7:0] prefix_byte(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'haa;
      3'd1:    v = 8'haa;
      3'd2:    v = 8'h03;
      3'd6:    v = 8'h88;
      3'd7:    v = 8'h8e;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] target_octet(input logic [47:0] addr,
                                              input logic [2:0]  k);
    logic [7:0] v;
    case (k)
      3'd0:    v = addr[7:0];
      3'd1:    v = addr[15:8];
      3'd2:    v = addr[23:16];
      3'd3:    v = addr[31:24];
      3'd4:    v = addr[39:32];
      3'd5:    v = addr[47:40];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: src/eic_front.sv
// ----------------------------------------------------------------------------
// eic_front
// Byte tracker: counts positions, captures the frame control word and
// accumulates address and prefix mismatch flags; emits a frame summary
// on the last byte.
// ----------------------------------------------------------------------------
module eic_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [47:0]          target_ap_address,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic [11:0]          in_captured_length,
  input  logic [15:0]          in_original_length,
  input  logic                 in_fcs_included,
  input  logic                 in_is_data_frame,
  input  logic                 in_timestamp_zero,
  input  logic [7:0]           in_channel,
  output logic                 sum_valid,
  input  logic                 sum_ready,
  output eic_pkg::frame_sum_t  sum_data
);

  logic [11:0] pos_r, pos_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic        ap_r, ap_nxt;
  logic        snap_r, snap_nxt;

  logic        accept;
  logic        take;
  logic [15:0] fc_cur;
  logic [11:0] plen;
  logic [11:0] hdr;
  logic [11:0] n_rx;
  logic [11:0] p_k;
  logic        cur_ap;
  logic        cur_snap;
  logic        fill_ap;
  logic        fill_snap;

  assign in_ready = sum_ready;
  assign accept   = in_valid && in_ready;
  assign take     = pos_r < eic_pkg::POS_LIMIT;
  assign plen     = eic_pkg::payload_len(in_captured_length, in_fcs_included);

  always_comb begin
    fc_cur = fc_r;
    if (take && pos_r == 12'd0) fc_cur[7:0]  = in_data_byte;
    if (take && pos_r == 12'd1) fc_cur[15:8] = in_data_byte;
  end

  assign hdr  = eic_pkg::hdr_len(fc_cur);
  assign n_rx = pos_r + {11'd0, take};

  // Checks on the byte in hand
  always_comb begin
    cur_ap   = 1'b0;
    cur_snap = 1'b0;
    if (take) begin
      if (fc_cur[8] && pos_r >= eic_pkg::AP_OFS_TO_DS && pos_r < 12'd10 &&
          in_data_byte != eic_pkg::target_octet(target_ap_address,
                                                pos_r[2:0] - 3'd4))
        cur_ap = 1'b1;
      if (!fc_cur[8] && pos_r >= eic_pkg::AP_OFS_FROM_DS && pos_r < 12'd16 &&
          in_data_byte != eic_pkg::target_octet(target_ap_address,
                                                pos_r[2:0] - 3'd2))
        cur_ap = 1'b1;
      if (pos_r >= hdr && pos_r < hdr + 12'd8 && pos_r < plen &&
          in_data_byte != eic_pkg::prefix_byte(pos_r[2:0] - hdr[2:0]))
        cur_snap = 1'b1;
    end
  end

  // Positions never received count as zero bytes
  always_comb begin
    fill_ap   = 1'b0;
    fill_snap = 1'b0;
    p_k       = '0;
    for (int k = 0; k < eic_pkg::AP_OCTETS; k++) begin
      if (eic_pkg::target_octet(target_ap_address, 3'(k)) != 8'h00) begin
        if (fc_cur[8] && (eic_pkg::AP_OFS_TO_DS + 12'(k)) >= n_rx)
          fill_ap = 1'b1;
        if (!fc_cur[8] && (eic_pkg::AP_OFS_FROM_DS + 12'(k)) >= n_rx)
          fill_ap = 1'b1;
      end
    end
    for (int k = 0; k < eic_pkg::PREFIX_BYTES; k++) begin
      p_k = hdr + 12'(k);
      if (eic_pkg::prefix_byte(3'(k)) != 8'h00 && p_k >= n_rx && p_k < plen)
        fill_snap = 1'b1;
    end
  end

  always_comb begin
    sum_valid                = in_valid && in_last_byte;
    sum_data.fc              = fc_cur;
    sum_data.ap_mismatch     = ap_r | cur_ap | fill_ap;
    sum_data.snap_mismatch   = snap_r | cur_snap | fill_snap;
    sum_data.captured_length = in_captured_length;
    sum_data.original_length = in_original_length;
    sum_data.fcs_included    = in_fcs_included;
    sum_data.is_data_frame   = in_is_data_frame;
    sum_data.timestamp_zero  = in_timestamp_zero;
    sum_data.channel         = in_channel;
  end

  always_comb begin
    pos_nxt  = pos_r;
    fc_nxt   = fc_r;
    ap_nxt   = ap_r;
    snap_nxt = snap_r;
    if (accept) begin
      if (in_last_byte) begin
        pos_nxt  = '0;
        fc_nxt   = '0;
        ap_nxt   = 1'b0;
        snap_nxt = 1'b0;
      end else begin
        pos_nxt  = n_rx;
        fc_nxt   = fc_cur;
        ap_nxt   = ap_r | cur_ap;
        snap_nxt = snap_r | cur_snap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fc_r   <= '0;
      ap_r   <= 1'b0;
      snap_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      fc_r   <= fc_nxt;
      ap_r   <= ap_nxt;
      snap_r <= snap_nxt;
    end
  end

endmodule

// File: src/eic_queue.sv
// ----------------------------------------------------------------------------
// eic_queue
// Small FIFO of frame summaries between front and back.
// ----------------------------------------------------------------------------
module eic_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  eic_pkg::frame_sum_t  push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output eic_pkg::frame_sum_t  pop_data
);

  eic_pkg::frame_sum_t mem_r [eic_pkg::QUEUE_DEPTH];

  logic [eic_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [eic_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [eic_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = count_r != (eic_pkg::QPTR_W+1)'(eic_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{eic_pkg::QPTR_W{1'b0}}, do_push}
                         - {{eic_pkg::QPTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/eic_verdict.sv
// ----------------------------------------------------------------------------
// eic_verdict
// Back end: turns a frame summary into a disposition and holds it in the
// output register until taken.
// ----------------------------------------------------------------------------
module eic_verdict (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [47:0]          target_ap_address,
  input  logic                 sum_valid,
  output logic                 sum_ready,
  input  eic_pkg::frame_sum_t  sum_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_disposition
);

  logic        valid_r, valid_nxt;
  logic [1:0]  disp_r, disp_nxt;
  logic [1:0]  verdict;
  logic [11:0] plen;
  logic [11:0] hdr;
  logic [15:0] cap_ext;
  logic [3:0]  subtype;

  assign plen    = eic_pkg::payload_len(sum_data.captured_length, sum_data.fcs_included);
  assign hdr     = eic_pkg::hdr_len(sum_data.fc);
  assign cap_ext = {4'd0, sum_data.captured_length};
  assign subtype = sum_data.fc[7:4];

  always_comb begin
    if (target_ap_address == '0 || target_ap_address[0])
      verdict = eic_pkg::DISP_INVALID;
    else if (sum_data.captured_length == '0)
      verdict = eic_pkg::DISP_INVALID;
    else if (!sum_data.is_data_frame)
      verdict = eic_pkg::DISP_IGNORE;
    else if (sum_data.fcs_included && sum_data.captured_length < eic_pkg::FCS_BYTES)
      verdict = eic_pkg::DISP_INVALID;
    else if (plen < eic_pkg::DATA_HDR_BYTES)
      verdict = eic_pkg::DISP_INVALID;
    else if (sum_data.fc[3:2] != eic_pkg::FC_TYPE_DATA)
      verdict = eic_pkg::DISP_INVALID;
    else if (sum_data.fc[8] == sum_data.fc[9])
      verdict = eic_pkg::DISP_IGNORE;
    else if (sum_data.ap_mismatch)
      verdict = eic_pkg::DISP_IGNORE;
    else if (sum_data.original_length == '0 || cap_ext > sum_data.original_length ||
             sum_data.timestamp_zero || sum_data.channel < eic_pkg::CHAN_MIN ||
             sum_data.channel > eic_pkg::CHAN_MAX)
      verdict = eic_pkg::DISP_RETAIN;
    else if (sum_data.fc[14])
      verdict = eic_pkg::DISP_IGNORE;
    else if (subtype == eic_pkg::SUBTYPE_NULL || subtype == eic_pkg::SUBTYPE_QOS_NULL)
      verdict = (sum_data.original_length == cap_ext && plen == hdr) ?
                eic_pkg::DISP_IGNORE : eic_pkg::DISP_RETAIN;
    else if (plen < hdr)
      verdict = eic_pkg::DISP_RETAIN;
    else
      verdict = sum_data.snap_mismatch ? eic_pkg::DISP_IGNORE : eic_pkg::DISP_RETAIN;
  end

  assign sum_ready       = !valid_r || out_ready;
  assign out_valid       = valid_r;
  assign out_disposition = disp_r;

  always_comb begin
    valid_nxt = valid_r;
    disp_nxt  = disp_r;
    if (sum_ready) begin
      valid_nxt = sum_valid;
      if (sum_valid) disp_nxt = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    disp_r <= disp_nxt;
  end

endmodule

// File: src/wlan_eapol_ingress_classifier.sv
// ----------------------------------------------------------------------------
// wlan_eapol_ingress_classifier
// Per-frame 802.11 disposition (invalid / ignore / retain) for EAPOL capture.
// ----------------------------------------------------------------------------
// Feed one captured frame byte per transaction, wire order, with the frame's
// metadata on every byte and in_last_byte on the final one; an empty frame is
// a single last transaction whose byte does not matter. The block takes one
// byte every cycle while in_ready is high. On the last byte the front end
// folds in any header bytes the frame never delivered (as zeros) and pushes
// a frame summary into a two-entry queue; the back end turns it into a
// verdict in the output register, which raises out_valid and holds the result
// until it is taken. in_ready falls only while the queue holds two summaries,
// i.e. when results are left waiting at the output. Write cfg_wr_data to set
// the watched AP MAC (first octet in bits 7..0) only while no frame is in
// flight.
// ----------------------------------------------------------------------------
module wlan_eapol_ingress_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [11:0] in_captured_length,
  input  logic [15:0] in_original_length,
  input  logic        in_fcs_included,
  input  logic        in_is_data_frame,
  input  logic        in_timestamp_zero,
  input  logic [7:0]  in_channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_disposition
);

  // Watched access point address
  logic [47:0] target_r, target_nxt;

  logic                push_valid;
  logic                push_ready;
  eic_pkg::frame_sum_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  eic_pkg::frame_sum_t pop_data;

  assign target_nxt = cfg_wr_en ? cfg_wr_data : target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) target_r <= '0;
    else        target_r <= target_nxt;
  end

  // Front: position tracking and per-byte compares
  eic_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .target_ap_address  (target_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .in_captured_length (in_captured_length),
    .in_original_length (in_original_length),
    .in_fcs_included    (in_fcs_included),
    .in_is_data_frame   (in_is_data_frame),
    .in_timestamp_zero  (in_timestamp_zero),
    .in_channel         (in_channel),
    .sum_valid          (push_valid),
    .sum_ready          (push_ready),
    .sum_data           (push_data)
  );

  // Decouple the byte stream from result back-pressure
  eic_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: verdict and output register
  eic_verdict u_verdict (
    .clk               (clk),
    .rst_n             (rst_n),
    .target_ap_address (target_r),
    .sum_valid         (pop_valid),
    .sum_ready         (pop_ready),
    .sum_data          (pop_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_disposition   (out_disposition)
  );

endmodule
